>>> design/kli_pkg.sv
// shared types and codes for the keyframe linear interpolator
// no dependencies; imported by every module of the block
`default_nettype none

package kli_pkg;

    // item action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // result position codes
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_INTERP = 2'd1;
    localparam logic [1:0] POS_LAST   = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_KEY_COUNT = 1'b0;

    // one keyframe entry as stored in the table
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_key;

    // request to the serial fraction divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

endpackage

`default_nettype wire

>>> design/kli_mem.sv
// keyframe table: one write port, one registered read port
// depends on kli_pkg for the entry type
`default_nettype none

module kli_mem
    import kli_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_key          i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_key               o_rdata
);

    t_key r_mem [DEPTH];
    t_key r_rdata;

    // write then registered read, old data on a same-cycle collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/kli_div.sv
// serial restoring divider for the segment fraction, one quotient bit a cycle
// depends on kli_pkg for the request struct
`default_nettype none

module kli_div
    import kli_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_req         i_req,
    output logic                  o_done,
    output logic [FRAC_BITS:0]    o_quo
);

    localparam int CW = $clog2(FRAC_BITS + 2);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [32:0]         r_rem;
    logic [31:0]         r_den;
    logic [FRAC_BITS:0]  r_quo;

    logic                w_ge;
    logic [32:0]         w_sub;

    // trial subtract of the divisor
    always_comb begin
        w_ge  = r_rem >= {1'b0, r_den};
        w_sub = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    // control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == 32'd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(FRAC_BITS + 1);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load on start, then subtract and shift while busy
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num};
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= {w_sub[31:0], 1'b0};
            r_quo <= {r_quo[FRAC_BITS-1:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

>>> design/kli_blend.sv
// shared subtract, multiply and add unit, run once per vector component
// depends on kli_pkg for the entry type
`default_nettype none

module kli_blend
    import kli_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_key              i_a,
    input  wire t_key              i_b,
    input  wire logic [FRAC_BITS:0] i_frac,
    output logic                   o_done,
    output logic [31:0]            o_x,
    output logic [31:0]            o_y,
    output logic [31:0]            o_z
);

    localparam int PW = 33 + FRAC_BITS + 2;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIFF = 4'b0010,
        B_MUL  = 4'b0100,
        B_ADD  = 4'b1000
    } t_blend_state;

    t_blend_state          r_state;
    t_blend_state          n_state;
    logic [1:0]            r_comp;
    logic                  r_done;
    t_key                  r_a;
    t_key                  r_b;
    logic [FRAC_BITS:0]    r_frac;
    logic signed [32:0]    r_diff;
    logic signed [PW-1:0]  r_prod;
    logic [31:0]           r_x;
    logic [31:0]           r_y;
    logic [31:0]           r_z;

    logic [31:0]           w_sel_a;
    logic [31:0]           w_sel_b;
    logic signed [FRAC_BITS+1:0] w_frac_s;
    logic signed [PW-1:0]  w_sum;

    // component select
    always_comb begin
        case (r_comp)
            2'd0:    begin w_sel_a = r_a.x; w_sel_b = r_b.x; end
            2'd1:    begin w_sel_a = r_a.y; w_sel_b = r_b.y; end
            default: begin w_sel_a = r_a.z; w_sel_b = r_b.z; end
        endcase
        w_frac_s = $signed({1'b0, r_frac});
        w_sum    = $signed({{(PW-32){w_sel_a[31]}}, w_sel_a}) + (r_prod >>> FRAC_BITS);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (i_start) n_state = B_DIFF;
            B_DIFF:  n_state = B_MUL;
            B_MUL:   n_state = B_ADD;
            B_ADD:   n_state = (r_comp == 2'd2) ? B_IDLE : B_DIFF;
            default: n_state = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_comp  <= 2'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == B_ADD) && (r_comp == 2'd2);
            if (i_start && r_state == B_IDLE) begin
                r_comp <= 2'd0;
            end else if (r_state == B_ADD) begin
                r_comp <= r_comp + 2'd1;
            end
        end
    end

    // datapath: b - a, times fraction, floor shift, plus a
    always_ff @(posedge i_clk) begin
        if (i_start && r_state == B_IDLE) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_frac <= i_frac;
        end
        if (r_state == B_DIFF) begin
            r_diff <= $signed({w_sel_b[31], w_sel_b}) - $signed({w_sel_a[31], w_sel_a});
        end
        if (r_state == B_MUL) begin
            r_prod <= r_diff * w_frac_s;
        end
        if (r_state == B_ADD) begin
            case (r_comp)
                2'd0:    r_x <= w_sum[31:0];
                2'd1:    r_y <= w_sum[31:0];
                default: r_z <= w_sum[31:0];
            endcase
        end
    end

    assign o_done = r_done;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

>>> design/keyframe_linear_interpolator.sv
// top level of the keyframe linear interpolator: sequencer, config register
// depends on kli_pkg, kli_mem, kli_div and kli_blend
//
// usage
//   input channel (i_in_valid / o_in_ready) carries load and query items.
//   a load item writes one table entry and gives no result; the next item
//   can follow at once. a load beyond the table is dropped.
//   a query item gives one result on the output channel (o_out_valid /
//   i_out_ready). ready stays low while a query is worked on.
//   query steps: a held first key goes straight to the final step; otherwise
//   keys are scanned from the table read port, then the serial divider and
//   the shared blend unit (one pass per component) run; a zero-length
//   segment skips the divider steps.
//   the result sits in an output register; the next query is taken once it
//   is written there, and a stalled receiver holds the block in its final
//   step until the register frees up.
//   key_count is written over the APB port (paddr 0), by the user only
//   while idle; the block does not enforce it. pready is always high.
//   reset sets key_count to 1, empties the output; table undefined until loaded.
`default_nettype none

module keyframe_linear_interpolator
    import kli_pkg::*;
#(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [5:0]  i_key_index,
    input  wire logic [31:0] i_key_time,
    input  wire logic [31:0] i_key_x,
    input  wire logic [31:0] i_key_y,
    input  wire logic [31:0] i_key_z,
    input  wire logic [31:0] i_query_time,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_out_x,
    output logic [31:0]      o_out_y,
    output logic [31:0]      o_out_z,
    output logic [5:0]       o_segment,
    output logic [1:0]       o_position
);

    localparam int IW = $clog2(MAX_KEYS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIRST = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DIV   = 6'b001000,
        S_BLEND = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [6:0]      r_key_count;
    logic [31:0]     r_q;
    logic [IW-1:0]   r_idx;
    t_key            r_prev;
    t_key            r_cur;
    logic [31:0]     r_res_x;
    logic [31:0]     r_res_y;
    logic [31:0]     r_res_z;
    logic [5:0]      r_res_seg;
    logic [1:0]      r_res_pos;
    logic            r_out_valid;
    logic [31:0]     r_out_x;
    logic [31:0]     r_out_y;
    logic [31:0]     r_out_z;
    logic [5:0]      r_out_seg;
    logic [1:0]      r_out_pos;

    logic            w_accept;
    logic            w_cfg_we;
    logic [IW-1:0]   w_last;
    logic [IW-1:0]   w_rd_addr;
    logic            w_we;
    t_key            w_wdata;
    t_key            w_cur;
    logic            w_hit;
    logic            w_at_last;
    logic            w_out_free;
    t_div_req        w_div_req;
    logic            w_div_done;
    logic [FRAC_BITS:0] w_frac;
    logic            w_blend_start;
    logic            w_blend_done;
    logic [31:0]     w_bl_x;
    logic [31:0]     w_bl_y;
    logic [31:0]     w_bl_z;

    // apb register access
    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_COUNT);
    assign prdata   = (paddr[2] == REG_KEY_COUNT) ? {25'd0, r_key_count} : 32'd0;

    // clamp the key count to a last index
    always_comb begin
        if (r_key_count == 7'd0) begin
            w_last = '0;
        end else if (32'(r_key_count) > 32'(MAX_KEYS)) begin
            w_last = IW'(MAX_KEYS - 1);
        end else begin
            w_last = IW'(r_key_count - 7'd1);
        end
    end

    // handshake and table write
    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_we       = w_accept && (i_action == ACT_LOAD) &&
                        (32'(i_key_index) < 32'(MAX_KEYS));
    assign w_wdata    = '{t: i_key_time, x: i_key_x, y: i_key_y, z: i_key_z};
    assign w_out_free = !r_out_valid || i_out_ready;

    // read address runs one entry ahead during the scan
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = '0;
            S_SCAN:  w_rd_addr = r_idx + IW'(2);
            default: w_rd_addr = r_idx + IW'(1);
        endcase
    end

    kli_mem #(
        .DEPTH (MAX_KEYS),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (IW'(i_key_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_cur)
    );

    // segment bracket test on the entry pair
    assign w_hit     = (r_prev.t <= r_q) && (r_q <= w_cur.t);
    assign w_at_last = (r_idx + IW'(1)) == w_last;

    always_comb begin
        w_div_req.start = (r_state == S_SCAN) && w_hit;
        w_div_req.num   = r_q - r_prev.t;
        w_div_req.den   = w_cur.t - r_prev.t;
    end

    kli_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_done  (w_div_done),
        .o_quo   (w_frac)
    );

    assign w_blend_start = (r_state == S_DIV) && w_div_done;

    kli_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_blend_start),
        .i_a     (r_prev),
        .i_b     (r_cur),
        .i_frac  (w_frac),
        .o_done  (w_blend_done),
        .o_x     (w_bl_x),
        .o_y     (w_bl_y),
        .o_z     (w_bl_z)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_action == ACT_QUERY) n_state = S_FIRST;
            end
            S_FIRST: begin
                if (w_last == '0 || r_q <= w_cur.t) n_state = S_DONE;
                else n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit) n_state = S_DIV;
                else if (w_at_last) n_state = S_DONE;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_BLEND;
            end
            S_BLEND: begin
                if (w_blend_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_count <= 7'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_we) begin
                r_key_count <= pwdata[6:0];
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan and result datapath
    always_ff @(posedge i_clk) begin
        if (w_accept && i_action == ACT_QUERY) begin
            r_q   <= i_query_time;
            r_idx <= '0;
        end
        if (r_state == S_FIRST) begin
            r_prev    <= w_cur;
            r_res_x   <= w_cur.x;
            r_res_y   <= w_cur.y;
            r_res_z   <= w_cur.z;
            r_res_seg <= 6'd0;
            r_res_pos <= POS_FIRST;
        end
        if (r_state == S_SCAN) begin
            if (w_hit) begin
                r_cur     <= w_cur;
                r_res_seg <= 6'(r_idx);
                r_res_pos <= POS_INTERP;
            end else if (w_at_last) begin
                r_res_x   <= w_cur.x;
                r_res_y   <= w_cur.y;
                r_res_z   <= w_cur.z;
                r_res_seg <= 6'(w_last);
                r_res_pos <= POS_LAST;
            end else begin
                r_prev <= w_cur;
                r_idx  <= r_idx + IW'(1);
            end
        end
        if (r_state == S_BLEND && w_blend_done) begin
            r_res_x <= w_bl_x;
            r_res_y <= w_bl_y;
            r_res_z <= w_bl_z;
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_x   <= r_res_x;
            r_out_y   <= r_res_y;
            r_out_z   <= r_res_z;
            r_out_seg <= r_res_seg;
            r_out_pos <= r_res_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;
    assign o_out_z     = r_out_z;
    assign o_segment   = r_out_seg;
    assign o_position  = r_out_pos;

    // a query holds off the next item
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_action == ACT_QUERY) |=> !o_in_ready)
        else $error("ready high right after a query item");

    // a held first key always reports segment zero
    a_first_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_position == POS_FIRST) |-> (o_segment == 6'd0))
        else $error("held first key with nonzero segment");

    // a new result only comes out of the final step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the final step");

    // divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside the divide step");

endmodule

`default_nettype wire
